### design/ssi_pkg.sv
// Shared types, constants and tables of the slope shortwave irradiance unit.
// Used by the CORDIC cell, the top level, checker and testbench; depends on nothing.
`default_nettype none
package ssi_pkg;

	// Number of CORDIC rotation cells per angle channel (8 to 24).
	localparam int CORDIC_STAGES = 16;
	// Quotient bits produced by the divider chain.
	localparam int DIV_BITS = 16;
	// Stages: two for the angle conversion, the CORDIC chain, six arithmetic
	// stages, the divider chain and the output register.
	localparam int PIPE_DEPTH = 2 + CORDIC_STAGES + 6 + DIV_BITS + 1;

	// CORDIC gain compensation in Q1.30.
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	// ceil(2^22 / 45): exact quotient by 45 for any 17 bit value.
	localparam logic [16:0] RECIP_45 = 17'd93207;
	localparam logic [16:0] DIV_45 = 17'd45;
	// Low sun limit, 3 degrees in 1/256 degree.
	localparam logic signed [15:0] LOW_SUN = 16'sd768;
	localparam logic [15:0] COS_ONE = 16'd32768;

	// Arctangent of 2^-i as a binary angle, 2^32 per turn.
	localparam logic [29:0] ATAN_BAM [24] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
		30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
		30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
	};

	// Fraction part of the degree to binary angle conversion:
	// entry r is floor((r * 2^21 + 22) / 45).
	typedef logic [20:0] bam_frac_tab_t [45];

	function automatic bam_frac_tab_t build_bam_frac();
		bam_frac_tab_t t;
		for (int r = 0; r < 45; r++) begin
			t[r] = 21'(((64'(r) << 21) + 64'd22) / 64'd45);
		end
		return t;
	endfunction

	localparam bam_frac_tab_t BAM_FRAC = build_bam_frac();

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_FLAT   = 2'd0,
		CFG_CORR   = 2'd1,
		CFG_SHADOW = 2'd2
	} cfg_idx_t;

	// Per-item data that rides beside the CORDIC chains.
	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [15:0] dir;
		logic signed [15:0] dif;
		logic               shade;
		logic               el_low;
		logic               flip_a;
		logic               flip_e;
	} side_t;

	// Per-item data that rides beside the divider chain.
	typedef struct packed {
		logic [15:0] cosq;
		logic [14:0] dif_out;
		logic [15:0] plain;
		logic        sat;
		logic        go;
	} dside_t;

endpackage
`default_nettype wire

### design/ssi_cordic_cell.sv
// One rotation-mode CORDIC iteration with registered outputs.
// Depends on ssi_pkg for the arctangent table.
`default_nettype none
module ssi_cordic_cell (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [4:0]         idx,
	input  wire logic signed [31:0] x_in,
	input  wire logic signed [31:0] y_in,
	input  wire logic signed [33:0] z_in,
	output logic signed [31:0]      x_q,
	output logic signed [31:0]      y_q,
	output logic signed [33:0]      z_q
);

	logic signed [31:0] dx, dy;
	logic signed [33:0] at;

	always_comb begin
		dx = y_in >>> idx;
		dy = x_in >>> idx;
		at = $signed({4'b0, ssi_pkg::ATAN_BAM[idx]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[33]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - at;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + at;
			end
		end
	end

endmodule
`default_nettype wire

### design/ssi_div_cell.sv
// One restoring division step: yields one quotient bit per cell, MSB first.
// Depends on nothing beyond its ports.
`default_nettype none
module ssi_div_cell (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [3:0]  idx,
	input  wire logic [46:0] r_in,
	input  wire logic [31:0] d_in,
	input  wire logic [15:0] q_in,
	output logic [46:0]      r_q,
	output logic [31:0]      d_q,
	output logic [15:0]      q_q
);

	logic [47:0] trial;
	logic        ge;

	always_comb begin
		trial = {16'b0, d_in} << idx;
		ge = {1'b0, r_in} >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= ge ? (r_in - trial[46:0]) : r_in;
			d_q <= d_in;
			q_q <= {q_in[14:0], ge};
		end
	end

endmodule
`default_nettype wire

### design/slope_shortwave_irradiance_unit.sv
// Top level of the slope shortwave irradiance unit: angle conversion, the two
// CORDIC chains, the incidence dot product, the divider chain and the output.
// Depends on ssi_pkg, ssi_cordic_cell and ssi_div_cell.
`default_nettype none
// The unit accepts one item per clock cycle while s_tready is high and
// returns one result item for each, in order: the angle stages turn azimuth
// and elevation into binary angles, each CORDIC cell does one iteration, the
// arithmetic stages form the sun vector, the incidence cosine and the divider
// operands, each of the sixteen divider cells yields one quotient bit, and
// the output register takes the result. The whole pipeline advances whenever
// the output register is empty or being taken, so s_tready is low only while
// a finished result waits on m_tready. Configuration writes take effect at
// once and should be made while the unit is empty.
module slope_shortwave_irradiance_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write port.
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [0:0]   cfg_wdata,
	// Input items.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// From bit 0: solar_azimuth[16:0], solar_elevation[32:17], normal_x[48:33],
	// normal_y[64:49], normal_z[80:65], direct_flat[96:81], diffuse_flat[112:97].
	input  wire logic [119:0] s_tdata,
	// From bit 0: shadowed.
	input  wire logic         s_tuser,
	// Result items.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// From bit 0: incidence_cosine[15:0], direct_on_slope[31:16],
	// diffuse_out[46:32], total_irradiance[62:47].
	output logic [63:0]       m_tdata
);

	localparam int NC = ssi_pkg::CORDIC_STAGES;
	localparam int ND = ssi_pkg::DIV_BITS;
	localparam int NP = ssi_pkg::PIPE_DEPTH;

	logic adv;
	logic [NP-1:0] vld_q;
	logic flat_q, corr_q, shadow_q;

	assign adv = !vld_q[NP-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NP-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q <= 1'b0;
			corr_q <= 1'b0;
			shadow_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssi_pkg::CFG_FLAT:   flat_q <= cfg_wdata[0];
				ssi_pkg::CFG_CORR:   corr_q <= cfg_wdata[0];
				ssi_pkg::CFG_SHADOW: shadow_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Valid bits shift with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NP-2:0], s_tvalid};
		end
	end

	// Stage 1: angle magnitude divided by 45 through a reciprocal product.
	logic [16:0] mag_a, mag_e;
	logic [33:0] pk_a, pk_e;
	logic [16:0] mag_a_s1, mag_e_s1;
	logic [11:0] k_a_s1, k_e_s1;
	logic        neg_e_s1;
	ssi_pkg::side_t sb_in, sb_s1, sb_s2;

	always_comb begin
		mag_a = s_tdata[16:0];
		mag_e = s_tdata[32] ? (17'd0 - {1'b1, s_tdata[32:17]}) : {1'b0, s_tdata[32:17]};
		pk_a = 34'(mag_a) * 34'(ssi_pkg::RECIP_45);
		pk_e = 34'(mag_e) * 34'(ssi_pkg::RECIP_45);
		sb_in.nx = $signed(s_tdata[48:33]);
		sb_in.ny = $signed(s_tdata[64:49]);
		sb_in.nz = $signed(s_tdata[80:65]);
		sb_in.dir = $signed(s_tdata[96:81]);
		sb_in.dif = $signed(s_tdata[112:97]);
		sb_in.shade = s_tuser;
		sb_in.el_low = $signed(s_tdata[32:17]) < ssi_pkg::LOW_SUN;
		sb_in.flip_a = 1'b0;
		sb_in.flip_e = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_a_s1 <= mag_a;
			mag_e_s1 <= mag_e;
			k_a_s1 <= pk_a[33:22];
			k_e_s1 <= pk_e[33:22];
			neg_e_s1 <= s_tdata[32];
			sb_s1 <= sb_in;
		end
	end

	// Stage 2: binary angle, then folding into [-90, 90) degrees.
	function automatic logic [31:0] to_bam(logic [16:0] mag, logic [11:0] k, logic neg);
		logic [16:0] rem;
		logic [31:0] q;
		rem = mag - 17'(17'(k) * ssi_pkg::DIV_45);
		q = {k[10:0], 21'b0} + {11'b0, ssi_pkg::BAM_FRAC[rem[5:0]]};
		return neg ? (32'd0 - q) : q;
	endfunction

	logic [31:0] bam_a, bam_e, sum_a, sum_e;
	logic flip_a, flip_e;
	logic signed [33:0] z_a_s2, z_e_s2;

	always_comb begin
		bam_a = to_bam(mag_a_s1, k_a_s1, 1'b0);
		bam_e = to_bam(mag_e_s1, k_e_s1, neg_e_s1);
		sum_a = bam_a + 32'h4000_0000;
		sum_e = bam_e + 32'h4000_0000;
		flip_a = sum_a[31];
		flip_e = sum_e[31];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_a_s2 <= 34'($signed(bam_a ^ {flip_a, 31'b0}));
			z_e_s2 <= 34'($signed(bam_e ^ {flip_e, 31'b0}));
			sb_s2 <= '{nx: sb_s1.nx, ny: sb_s1.ny, nz: sb_s1.nz, dir: sb_s1.dir,
				dif: sb_s1.dif, shade: sb_s1.shade, el_low: sb_s1.el_low,
				flip_a: flip_a, flip_e: flip_e};
		end
	end

	// CORDIC chains, one cell per iteration, side data in step.
	logic signed [31:0] xa [NC+1];
	logic signed [31:0] ya [NC+1];
	logic signed [33:0] za [NC+1];
	logic signed [31:0] xe [NC+1];
	logic signed [31:0] ye [NC+1];
	logic signed [33:0] ze [NC+1];
	ssi_pkg::side_t sb_c [NC+1];

	assign xa[0] = ssi_pkg::CORDIC_GAIN;
	assign ya[0] = '0;
	assign za[0] = z_a_s2;
	assign xe[0] = ssi_pkg::CORDIC_GAIN;
	assign ye[0] = '0;
	assign ze[0] = z_e_s2;
	assign sb_c[0] = sb_s2;

	for (genvar g = 0; g < NC; g++) begin : g_cordic
		ssi_cordic_cell u_cell_a (
			.clk(clk), .en(adv), .idx(5'(g)),
			.x_in(xa[g]), .y_in(ya[g]), .z_in(za[g]),
			.x_q(xa[g+1]), .y_q(ya[g+1]), .z_q(za[g+1])
		);
		ssi_cordic_cell u_cell_e (
			.clk(clk), .en(adv), .idx(5'(g)),
			.x_in(xe[g]), .y_in(ye[g]), .z_in(ze[g]),
			.x_q(xe[g+1]), .y_q(ye[g+1]), .z_q(ze[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				sb_c[g+1] <= sb_c[g];
			end
		end
	end

	// Stage 3: undo the half-turn fold.
	logic signed [31:0] cos_a_s3, sin_a_s3, cos_e_s3, sin_e_s3;
	ssi_pkg::side_t sb_s3, sb_s4, sb_s5, sb_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_a_s3 <= sb_c[NC].flip_a ? -xa[NC] : xa[NC];
			sin_a_s3 <= sb_c[NC].flip_a ? -ya[NC] : ya[NC];
			cos_e_s3 <= sb_c[NC].flip_e ? -xe[NC] : xe[NC];
			sin_e_s3 <= sb_c[NC].flip_e ? -ye[NC] : ye[NC];
			sb_s3 <= sb_c[NC];
		end
	end

	// Stage 4: horizontal components of the sun vector.
	logic signed [63:0] px_s4, py_s4;
	logic signed [31:0] sin_e_s4, sin_e_s5, sin_e_s6, sin_e_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4 <= 64'(cos_e_s3) * 64'(sin_a_s3);
			py_s4 <= 64'(cos_e_s3) * 64'(cos_a_s3);
			sin_e_s4 <= sin_e_s3;
			sb_s4 <= sb_s3;
		end
	end

	// Stage 5: products with the surface normal, vertical in flat mode.
	logic signed [33:0] sx, sy;
	logic signed [15:0] nx_u, ny_u, nz_u;
	logic signed [49:0] tx_s5, ty_s5, tz_s5;

	always_comb begin
		sx = px_s4[63:30];
		sy = py_s4[63:30];
		nx_u = flat_q ? 16'sd0 : sb_s4.nx;
		ny_u = flat_q ? 16'sd0 : sb_s4.ny;
		nz_u = flat_q ? 16'sd16384 : sb_s4.nz;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s5 <= 50'(sx) * 50'(nx_u);
			ty_s5 <= 50'(sy) * 50'(ny_u);
			tz_s5 <= 50'(sin_e_s4) * 50'(nz_u);
			sin_e_s5 <= sin_e_s4;
			sb_s5 <= sb_s4;
		end
	end

	// Stage 6: dot product rounded to Q1.15 and clamped.
	logic signed [51:0] dot;
	logic signed [22:0] cos_raw;
	logic [15:0] cosq_c, cosq_s6;

	always_comb begin
		dot = 52'(tx_s5) + 52'(ty_s5) + 52'(tz_s5) + (52'sd1 <<< 28);
		cos_raw = 23'(dot >>> 29);
		if (cos_raw[22] || sb_s5.el_low) begin
			cosq_c = '0;
		end else if (cos_raw > 23'sd32768) begin
			cosq_c = ssi_pkg::COS_ONE;
		end else begin
			cosq_c = cos_raw[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cosq_s6 <= cosq_c;
			sin_e_s6 <= sin_e_s5;
			sb_s6 <= sb_s5;
		end
	end

	// Stage 7: scaled direct beam and the decision whether it counts at all.
	logic dir_pos;
	logic [30:0] num_s7;
	logic go_s7;
	logic [15:0] cosq_s7;
	logic signed [15:0] dif_s7;

	assign dir_pos = !sb_s6.dir[15] && (sb_s6.dir != 16'sd0);

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7 <= 31'(cosq_s6) * 31'(sb_s6.dir[14:0]);
			go_s7 <= (cosq_s6 != 16'd0) && dir_pos && !(shadow_q && sb_s6.shade)
				&& (!corr_q || (sin_e_s6 > 32'sd0));
			cosq_s7 <= cosq_s6;
			dif_s7 <= sb_s6.dif;
			sin_e_s7 <= sin_e_s6;
		end
	end

	// Stage 8: divider operands, rounding by half the divisor, overflow check.
	logic [46:0] numer;
	logic [31:0] denom;
	logic [30:0] plain_sum;
	logic [46:0] n_s8;
	logic [31:0] d_s8;
	ssi_pkg::dside_t ds_s8;

	always_comb begin
		numer = {1'b0, num_s7[29:0], 16'b0} + 47'(sin_e_s7[30:0]);
		denom = {sin_e_s7[30:0], 1'b0};
		plain_sum = num_s7 + 31'd16384;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s8 <= numer;
			d_s8 <= denom;
			ds_s8.cosq <= cosq_s7;
			ds_s8.dif_out <= dif_s7[15] ? 15'd0 : dif_s7[14:0];
			ds_s8.plain <= plain_sum[30:15];
			ds_s8.sat <= {1'b0, numer} >= {denom, 16'b0};
			ds_s8.go <= go_s7;
		end
	end

	// Divider chain, one quotient bit per cell.
	logic [46:0] rr [ND+1];
	logic [31:0] dd [ND+1];
	logic [15:0] qq [ND+1];
	ssi_pkg::dside_t ds_c [ND+1];

	assign rr[0] = n_s8;
	assign dd[0] = d_s8;
	assign qq[0] = '0;
	assign ds_c[0] = ds_s8;

	for (genvar g = 0; g < ND; g++) begin : g_div
		ssi_div_cell u_cell (
			.clk(clk), .en(adv), .idx(4'(ND - 1 - g)),
			.r_in(rr[g]), .d_in(dd[g]), .q_in(qq[g]),
			.r_q(rr[g+1]), .d_q(dd[g+1]), .q_q(qq[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				ds_c[g+1] <= ds_c[g];
			end
		end
	end

	// Output register: pick the direct value, add diffuse with saturation.
	logic [15:0] direct_c;
	logic [16:0] total_sum;
	logic [15:0] cos_o_q, direct_o_q, total_o_q;
	logic [14:0] dif_o_q;

	always_comb begin
		if (!ds_c[ND].go) begin
			direct_c = '0;
		end else if (corr_q) begin
			direct_c = ds_c[ND].sat ? 16'hFFFF : qq[ND];
		end else begin
			direct_c = ds_c[ND].plain;
		end
		total_sum = {1'b0, direct_c} + {2'b0, ds_c[ND].dif_out};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_o_q <= ds_c[ND].cosq;
			direct_o_q <= direct_c;
			dif_o_q <= ds_c[ND].dif_out;
			total_o_q <= total_sum[16] ? 16'hFFFF : total_sum[15:0];
		end
	end

	assign m_tdata = {1'b0, total_o_q, dif_o_q, direct_o_q, cos_o_q};

`ifndef SYNTHESIS
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] <= ssi_pkg::COS_ONE))
		else $error("incidence cosine above one");
	a_direct_needs_cos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[31:16] != 16'd0)) |-> (m_tdata[15:0] != 16'd0))
		else $error("direct beam with zero incidence cosine");
	a_total_ge_diffuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[62:47] >= {1'b0, m_tdata[46:32]}))
		else $error("total below diffuse");
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while the pipeline is stalled");
`endif

endmodule
`default_nettype wire

### verif/ssi_checker.sv
// Result checker for the slope shortwave irradiance unit: watches the config
// port and both streams, predicts each result item and compares it in order.
// Depends on ssi_pkg for the register index names and the CORDIC cell count.
`default_nettype none
module ssi_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [0:0]   cfg_wdata,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [119:0] s_tdata,
	input  wire logic         s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [63:0]  m_tdata,
	output int                errors,
	output int                pending
);

	// Listed from the highest bits down, so cosq lands in bits 15:0.
	typedef struct packed {
		logic [15:0] total;
		logic [14:0] diffuse;
		logic [15:0] direct;
		logic [15:0] cosq;
	} irr_t;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint ARCTAN [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	logic flat_mode, corr_mode, shadow_mode;
	irr_t irr_q[$];

	assign pending = irr_q.size();

	// Degrees in 1/256 units to a binary angle, rounding the magnitude half up.
	function automatic logic [31:0] deg_to_bam(input longint v);
		longint mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = ((mag <<< 24) + 180) / 360;
		if (v < 0) begin
			q = -q;
		end
		return q[31:0];
	endfunction

	// Rotation-mode CORDIC; the left half-plane is folded over by 180 degrees.
	function automatic void sun_rotate(input logic [31:0] ang, output longint c,
			output longint s);
		logic flip;
		logic [31:0] sum;
		logic [31:0] b;
		longint x, y, z, dx, dy;
		sum = ang + 32'h40000000;
		flip = sum[31];
		b = flip ? (ang ^ 32'h80000000) : ang;
		z = longint'(signed'(b));
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < ssi_pkg::CORDIC_STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic irr_t predict_irradiance(input logic [119:0] d, input logic shade);
		irr_t r;
		longint az, el, nx, ny, nz, dir, dif;
		longint ca, sa, ce, se, dot, cosq, direct, diffuse, total;
		az = longint'(d[16:0]);
		el = longint'(signed'(d[32:17]));
		nx = longint'(signed'(d[48:33]));
		ny = longint'(signed'(d[64:49]));
		nz = longint'(signed'(d[80:65]));
		dir = longint'(signed'(d[96:81]));
		dif = longint'(signed'(d[112:97]));
		sun_rotate(deg_to_bam(az), ca, sa);
		sun_rotate(deg_to_bam(el), ce, se);
		if (flat_mode) begin
			nx = 0; ny = 0; nz = 16384;
		end
		dot = ((ce * sa) >>> 30) * nx + ((ce * ca) >>> 30) * ny + se * nz;
		cosq = (dot + (64'sd1 <<< 28)) >>> 29;
		if (cosq < 0 || el < 768) begin
			cosq = 0;
		end
		if (cosq > 32768) begin
			cosq = 32768;
		end
		direct = 0;
		if (cosq > 0 && dir > 0 && !(shadow_mode && shade)) begin
			if (corr_mode) begin
				if (se > 0) begin
					direct = (2 * cosq * dir * 32768 + se) / (2 * se);
				end
			end else begin
				direct = (cosq * dir + 16384) >>> 15;
			end
		end
		if (direct > 65535) begin
			direct = 65535;
		end
		diffuse = (dif > 0) ? dif : 0;
		total = direct + diffuse;
		if (total > 65535) begin
			total = 65535;
		end
		r.cosq = cosq[15:0];
		r.direct = direct[15:0];
		r.diffuse = diffuse[14:0];
		r.total = total[15:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		irr_t got, want;
		if (!arst_n) begin
			flat_mode <= 1'b0;
			corr_mode <= 1'b0;
			shadow_mode <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (ssi_pkg::cfg_idx_t'(cfg_index))
					ssi_pkg::CFG_FLAT:   flat_mode <= cfg_wdata[0];
					ssi_pkg::CFG_CORR:   corr_mode <= cfg_wdata[0];
					ssi_pkg::CFG_SHADOW: shadow_mode <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				irr_q.push_back(predict_irradiance(s_tdata, s_tuser));
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[62:0];
				if (irr_q.size() == 0) begin
					report_mismatch("unexpected result item", 1, 0);
				end else begin
					want = irr_q.pop_front();
					if (got.cosq !== want.cosq)
						report_mismatch("incidence_cosine", got.cosq, want.cosq);
					if (got.direct !== want.direct)
						report_mismatch("direct_on_slope", got.direct, want.direct);
					if (got.diffuse !== want.diffuse)
						report_mismatch("diffuse_out", got.diffuse, want.diffuse);
					if (got.total !== want.total)
						report_mismatch("total_irradiance", got.total, want.total);
				end
			end
		end
	end
endmodule
`default_nettype wire

### verif/testbench.sv
// Top of the slope shortwave irradiance unit testbench: clock, reset, config
// phases, bursty stimulus and a stalling receiver. Depends on ssi_pkg, the
// unit itself and ssi_checker, which predicts and compares every result item.
`default_nettype none
module testbench;

	// Elevation in 1/256 degree; 768 is the low-sun limit of three degrees.
	localparam int EL_MAX = 23040;
	localparam int AZ_MAX = 92159;
	localparam int N_MAX = 16384;
	localparam int RANDOM_PER_PHASE = 274;
	localparam int DRAIN_CYCLES = ssi_pkg::PIPE_DEPTH + 8;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [0:0]   cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	int           errors;
	int           pending;
	// Set by the stimulus once; the receiver then refuses results for a long
	// stretch so the pipeline fills and s_tready drops.
	logic         hold_req;
	int           burst_left;

	slope_shortwave_irradiance_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ssi_checker irr_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far above the slowest legal run of about 1750 items.
	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: the stall pattern is drawn anew periodically from always ready,
	// half ready and mostly stalled. A long hold-off is taken once.
	initial begin
		int mode;
		int hold_left;
		int cyc;
		m_tready = 1'b0;
		mode = 0;
		hold_left = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (cyc % 64 == 0) begin
				mode = $urandom_range(0, 2);
			end
			cyc++;
			if (hold_req && hold_left == 0 && cyc > 0) begin
				hold_left = 300;
			end
			if (hold_left > 1) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (hold_left == 1) begin
					hold_left = -1;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	function automatic logic [119:0] pack_item(input int az, input int el, input int nx,
			input int ny, input int nz, input int dir, input int dif);
		return {7'b0, 16'(dif), 16'(dir), 16'(nz), 16'(ny), 16'(nx), 16'(el), 17'(az)};
	endfunction

	task automatic write_reg(input ssi_pkg::cfg_idx_t idx, input logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one item and returns after the edge that takes it. Between bursts
	// the valid line drops for a random gap; within a burst it stays high.
	task automatic offer_item(input logic [119:0] d, input logic shade);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= shade;
		// s_tready is stable at the falling edge; if high, the next rising
		// edge takes the item.
		forever begin
			@(negedge clk);
			if (s_tready) begin
				break;
			end
		end
		@(posedge clk);
	endtask

	task automatic directed_items();
		offer_item(pack_item(0, 0, 0, 0, N_MAX, 1000, 1000), 1'b0);
		offer_item(pack_item(0, EL_MAX, 0, 0, N_MAX, 32767, 32767), 1'b0);
		offer_item(pack_item(AZ_MAX, EL_MAX, -N_MAX, -N_MAX, -N_MAX, 32767, -32768), 1'b1);
		offer_item(pack_item(23040, 767, N_MAX, 0, 0, 20000, 500), 1'b0);
		offer_item(pack_item(23040, 768, N_MAX, 0, 0, 20000, 500), 1'b0);
		offer_item(pack_item(46080, -EL_MAX, 0, N_MAX, 0, -32768, 32767), 1'b1);
		offer_item(pack_item(69120, 2560, N_MAX, 0, 0, 32767, 0), 1'b0);
		offer_item(pack_item(69120, 2560, -N_MAX, 0, 0, 32767, 0), 1'b1);
		offer_item(pack_item(0, 5000, 0, N_MAX, 0, 0, -1), 1'b0);
		// A normal well above unit length drives the cosine into saturation.
		offer_item(pack_item(1000, 15000, N_MAX, N_MAX, N_MAX, 32767, 32767), 1'b0);
		offer_item(pack_item(1000, 768, N_MAX, N_MAX, N_MAX, 32767, 32767), 1'b1);
		// Low elevation with a steep normal facing the sun: large corrected gain.
		offer_item(pack_item(0, 800, 0, N_MAX, 0, 32767, 100), 1'b0);
		offer_item(pack_item(AZ_MAX, 12000, 0, 0, 0, 1, 1), 1'b1);
		offer_item(pack_item(65535, 20000, 8000, -8000, 12000, -1, 32767), 1'b0);
		offer_item(pack_item(65536, 20000, 8000, 8000, 12000, 32767, 32767), 1'b1);
		offer_item(pack_item(12345, -1, 0, 0, N_MAX, 32767, 5), 1'b0);
		offer_item(pack_item(90000, 3000, -12000, 9000, 6000, 15000, 15000), 1'b1);
		offer_item(pack_item(45000, 11520, 0, 0, N_MAX, 1, -32768), 1'b0);
	endtask

	task automatic random_items(input int count);
		int az, el, nx, ny, nz, dir, dif;
		for (int i = 0; i < count; i++) begin
			az = $urandom_range(0, AZ_MAX);
			// Most items have the sun up, where the interesting arithmetic lives.
			if ($urandom_range(0, 3) == 0) begin
				el = int'($urandom_range(0, 2 * EL_MAX)) - EL_MAX;
			end else begin
				el = $urandom_range(700, EL_MAX);
			end
			if ($urandom_range(0, 2) == 0) begin
				nx = int'($urandom_range(0, 2 * N_MAX)) - N_MAX;
				ny = int'($urandom_range(0, 2 * N_MAX)) - N_MAX;
				nz = int'($urandom_range(0, 2 * N_MAX)) - N_MAX;
			end else begin
				// Roughly unit-length normals on the upper half.
				nx = int'($urandom_range(0, 2 * 9000)) - 9000;
				ny = int'($urandom_range(0, 2 * 9000)) - 9000;
				nz = $urandom_range(9000, N_MAX);
			end
			dir = int'($urandom_range(0, 65535)) - 32768;
			dif = int'($urandom_range(0, 65535)) - 32768;
			offer_item(pack_item(az, el, nx, ny, nz, dir, dif), 1'($urandom_range(0, 1)));
		end
	endtask

	// Waits until every expected result has arrived, then lets the pipeline
	// run empty so that nothing is still in flight.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic flat, input logic corr, input logic shadow);
		write_reg(ssi_pkg::CFG_FLAT, flat);
		write_reg(ssi_pkg::CFG_CORR, corr);
		write_reg(ssi_pkg::CFG_SHADOW, shadow);
		burst_left = 0;
		directed_items();
		random_items(RANDOM_PER_PHASE);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// First phase runs on the reset values of all registers.
		directed_items();
		hold_req <= 1'b1;
		random_items(RANDOM_PER_PHASE);
		drain();
		run_phase(1'b0, 1'b1, 1'b0);
		run_phase(1'b0, 1'b0, 1'b1);
		run_phase(1'b1, 1'b0, 1'b1);
		run_phase(1'b1, 1'b1, 1'b1);
		run_phase(1'b0, 1'b1, 1'b1);

		if (errors == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
design/ssi_pkg.sv
design/ssi_cordic_cell.sv
design/ssi_div_cell.sv
design/slope_shortwave_irradiance_unit.sv
verif/ssi_checker.sv
verif/testbench.sv
